[sv/assert_macros.svh]
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ffe_pkg.sv]
// Types and constants for the fire effect field engine
package ffe_pkg;

    localparam int FIELD_WIDTH   = 80;
    localparam int FIELD_HEIGHT  = 100;
    localparam int SCREEN_HEIGHT = 240;

    localparam int CELLS       = FIELD_WIDTH * FIELD_HEIGHT;
    localparam int BOTTOM_BASE = (FIELD_HEIGHT - 1) * FIELD_WIDTH;
    localparam int RISE_CELLS  = BOTTOM_BASE;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int CNT_W       = $clog2(CELLS + 2 * FIELD_WIDTH);

    localparam logic [31:0] SEED_RESET = 32'h0000_1234;
    localparam logic [15:0] LCG_MULT   = 16'h8405;

    localparam logic [23:0] STRIP_COLOUR = 24'h202028;
    localparam logic [7:0]  RAMP_HOT     = 8'd0;
    localparam logic [7:0]  RAMP_MID     = 8'd85;
    localparam logic [7:0]  RAMP_COLD    = 8'd170;
    localparam logic [7:0]  CHAN_MAX     = 8'hFF;

    localparam logic [1:0] MODE_RED   = 2'd0;
    localparam logic [1:0] MODE_GREEN = 2'd1;

    localparam logic CMD_ADVANCE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_OUT,
        ST_SEED,
        ST_RISE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PK_BLACK,
        PK_FIELD,
        PK_STRIP
    } t_pix_kind;

endpackage

[sv/ffe_ram.sv]
// Generic RAM: one write port, two registered read ports
module ffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/fire_effect_field_engine.sv]
// Fire effect field engine top level: field store, sequencer and palette
// After reset the block sweeps the 8000-cell field to zero, one cell a cycle, and takes
// no word during the sweep; configuration writes are taken at any time. A pixel read
// passes through the read state and the output state into the output register. A frame
// advance seeds the bottom row and then propagates the field, all through the field RAM's
// single write port, which the average unit fills with one cell per cycle. One word is
// in flight at a time; a finished result waits in the output register while the next word
// is accepted.
module fire_effect_field_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [8:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_frame_done
);

    import ffe_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_seed, n_seed;
    logic [1:0]       r_color_mode;
    logic [ADDR_W-1:0] r_pix_idx;
    t_pix_kind        r_pix_kind;

    logic              r_rd_act;
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_dest;
    logic              r_oob_a, r_oob_b;
    logic [7:0]        r_win0, r_win1;

    logic              r_out_valid;
    logic [7:0]        r_red, r_green, r_blue;
    logic              r_frame_done;

    logic              out_free, out_load, out_done;
    logic [7:0]        out_r, out_g, out_b;
    logic              accept;

    logic [47:0]       lcg_prod;
    logic [CNT_W-1:0]  addr_a_full, addr_b_full;
    logic              oob_a, oob_b;

    logic              ram_we, ram_re_a, ram_re_b;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [7:0]        ram_wdata, ram_rdata_a, ram_rdata_b;

    logic [7:0]        cell_a, cell_b, avg_val;
    logic [9:0]        avg_sum;
    logic [7:0]        hot, mid, cold;

    function automatic logic [7:0] ramp(input logic [7:0] i, input logic [7:0] start);
        logic [9:0] v;
        v = 10'(i - start) * 10'd3;
        if (i < start) begin
            return 8'd0;
        end
        return (v > 10'(CHAN_MAX)) ? CHAN_MAX : v[7:0];
    endfunction

    ffe_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_field (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re_a   (ram_re_a),
        .i_raddr_a(ram_raddr_a),
        .o_rdata_a(ram_rdata_a),
        .i_re_b   (ram_re_b),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_b(ram_rdata_b)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign lcg_prod = r_seed * LCG_MULT;

    assign addr_a_full = CNT_W'(FIELD_WIDTH) + r_cnt;
    assign addr_b_full = CNT_W'(2 * FIELD_WIDTH - 1) + r_cnt;
    assign oob_a       = addr_a_full >= CNT_W'(CELLS);
    assign oob_b       = addr_b_full >= CNT_W'(CELLS);

    assign cell_a  = r_oob_a ? 8'd0 : ram_rdata_a;
    assign cell_b  = r_oob_b ? 8'd0 : ram_rdata_b;
    assign avg_sum = 10'(r_win0) + 10'(r_win1) + 10'(cell_a) + 10'(cell_b);
    assign avg_val = (avg_sum[9:2] == 8'd0) ? 8'd0 : avg_sum[9:2] - 8'd1;

    assign hot  = ramp(ram_rdata_a, RAMP_HOT);
    assign mid  = ramp(ram_rdata_a, RAMP_MID);
    assign cold = ramp(ram_rdata_a, RAMP_COLD);

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re_a    = 1'b0;
        ram_raddr_a = r_pix_idx;
        ram_re_b    = 1'b0;
        ram_raddr_b = oob_b ? '0 : addr_b_full[ADDR_W-1:0];
        if (r_wb_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_wb_dest;
            ram_wdata = avg_val;
        end else if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[ADDR_W-1:0];
        end else if (r_state == ST_SEED) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(BOTTOM_BASE) + r_cnt[ADDR_W-1:0];
            ram_wdata = lcg_prod[39:32];
        end
        if (r_state == ST_RISE) begin
            ram_re_a    = 1'b1;
            ram_raddr_a = oob_a ? '0 : addr_a_full[ADDR_W-1:0];
            ram_re_b    = 1'b1;
        end else if (r_state == ST_PIX_RD) begin
            ram_re_a = 1'b1;
        end
    end

    always_comb begin
        case (r_pix_kind)
            PK_FIELD: begin
                case (r_color_mode)
                    MODE_RED: begin
                        out_r = hot;
                        out_g = mid;
                        out_b = cold;
                    end
                    MODE_GREEN: begin
                        out_r = mid;
                        out_g = hot;
                        out_b = cold;
                    end
                    default: begin
                        out_r = mid;
                        out_g = cold;
                        out_b = hot;
                    end
                endcase
            end
            PK_STRIP: begin
                out_r = STRIP_COLOUR[23:16];
                out_g = STRIP_COLOUR[15:8];
                out_b = STRIP_COLOUR[7:0];
            end
            default: begin
                out_r = 8'd0;
                out_g = 8'd0;
                out_b = 8'd0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_seed     = r_seed;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        out_done   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    n_state = (i_cmd == CMD_ADVANCE) ? ST_SEED : ST_PIX_RD;
                end
            end
            ST_PIX_RD: begin
                n_state = ST_PIX_OUT;
            end
            ST_PIX_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_SEED: begin
                n_seed = lcg_prod[31:0] + 32'd1;
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FIELD_WIDTH - 1)) begin
                    n_state = ST_RISE;
                    n_cnt   = '0;
                end
            end
            ST_RISE: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RISE_CELLS + 1)) begin
                    n_state = ST_DONE;
                    n_cnt   = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_done = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cnt        <= '0;
            r_seed       <= SEED_RESET;
            r_color_mode <= MODE_RED;
            r_rd_act     <= 1'b0;
            r_wb_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_seed     <= n_seed;
            r_rd_act   <= (r_state == ST_RISE);
            r_wb_valid <= (r_state == ST_RISE) && (r_cnt >= CNT_W'(2));
            if (i_cfg_we) begin
                r_color_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_dest <= ADDR_W'(r_cnt - CNT_W'(2));
        r_oob_a   <= oob_a;
        r_oob_b   <= oob_b;
        if (r_rd_act) begin
            r_win0 <= r_win1;
            r_win1 <= cell_a;
        end
        if (accept) begin
            r_pix_idx <= ADDR_W'(32'(i_pixel_y[7:1]) * FIELD_WIDTH + 32'(i_pixel_x[8:2]));
            if (32'(i_pixel_x) >= 32'(4 * FIELD_WIDTH) ||
                32'(i_pixel_y) >= 32'(SCREEN_HEIGHT)) begin
                r_pix_kind <= PK_BLACK;
            end else if (32'(i_pixel_y) < 32'(2 * FIELD_HEIGHT)) begin
                r_pix_kind <= PK_FIELD;
            end else begin
                r_pix_kind <= PK_STRIP;
            end
        end
        if (out_load) begin
            r_frame_done <= out_done;
            r_red        <= out_done ? 8'd0 : out_r;
            r_green      <= out_done ? 8'd0 : out_g;
            r_blue       <= out_done ? 8'd0 : out_b;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_frame_done = r_frame_done;

endmodule

[sv/ffe_checker.sv]
// Port-level checker for the fire effect field engine, bound to the top level
`include "assert_macros.svh"

module ffe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_frame_done
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_frame_done), "result word changed while stalled")
    `ASSERT_SAME(a_done_black, i_clk, i_rst_n, o_out_valid && o_frame_done, o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0, "frame advance result carries colour")
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second word accepted while one is in flight")
    `ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result appeared without a word being processed")

endmodule

bind fire_effect_field_engine ffe_checker u_ffe_checker (.*);

[bench/fire_field_checker.sv]
`timescale 1ns / 1ps
// Fire field checker: tracks field, seed and palette, predicts every result word and compares
module fire_field_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_cmd,
    input  logic [8:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_frame_done,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_frames,
    output int         o_pixels
);

    import ffe_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_done;
    } t_pixel_word;

    logic [7:0]  heat [CELLS];
    logic [31:0] seed;
    logic [1:0]  palette_mode;
    t_pixel_word expected_words [$];
    int          mismatch_cnt;
    int          frames_seen;
    int          pixels_seen;
    int          words_checked;

    assign o_mismatches = mismatch_cnt;
    assign o_frames     = frames_seen;
    assign o_pixels     = pixels_seen;

    initial begin
        mismatch_cnt  = 0;
        frames_seen   = 0;
        pixels_seen   = 0;
        words_checked = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        $display("[%0t] word %0d %s: got %0h, want %0h", $time, words_checked, what, got, want);
    endtask

    function automatic logic [7:0] level_at(input int idx);
        return (idx < CELLS) ? heat[idx] : 8'd0;
    endfunction

    function automatic logic [7:0] ramp(input logic [7:0] level, input logic [7:0] start);
        int v;
        if (level < start)
            return 8'd0;
        v = (int'(level) - int'(start)) * 3;
        return (v > 255) ? CHAN_MAX : 8'(v);
    endfunction

    function automatic void advance_frame();
        logic [63:0] prod;
        int          sum;
        for (int c = 0; c < FIELD_WIDTH; c++) begin
            prod = 64'(seed) * 64'(LCG_MULT);
            seed = prod[31:0] + 32'd1;
            heat[BOTTOM_BASE + c] = prod[39:32];
        end
        // ascending order only reads cells not yet overwritten by propagation this frame
        for (int d = 0; d < RISE_CELLS; d++) begin
            sum = int'(level_at(d + FIELD_WIDTH)) + int'(level_at(d + FIELD_WIDTH + 1))
                + int'(level_at(d + FIELD_WIDTH + 2)) + int'(level_at(d + 2 * FIELD_WIDTH + 1));
            sum = sum >> 2;
            if (sum > 0)
                sum--;
            heat[d] = 8'(sum);
        end
    endfunction

    function automatic t_pixel_word read_pixel(input logic [8:0] x, input logic [7:0] y);
        t_pixel_word w;
        logic [7:0]  lvl;
        logic [7:0]  hot;
        logic [7:0]  mid;
        logic [7:0]  cold;
        logic [23:0] rgb;
        rgb = '0;
        if (int'(x) >= 4 * FIELD_WIDTH || int'(y) >= SCREEN_HEIGHT) begin
            rgb = '0;
        end else if (int'(y) < 2 * FIELD_HEIGHT) begin
            lvl  = level_at(int'(y >> 1) * FIELD_WIDTH + int'(x >> 2));
            hot  = ramp(lvl, RAMP_HOT);
            mid  = ramp(lvl, RAMP_MID);
            cold = ramp(lvl, RAMP_COLD);
            case (palette_mode)
                MODE_RED:   rgb = {hot, mid, cold};
                MODE_GREEN: rgb = {mid, hot, cold};
                default:    rgb = {mid, cold, hot};
            endcase
        end else begin
            rgb = STRIP_COLOUR;
        end
        w.red        = rgb[23:16];
        w.green      = rgb[15:8];
        w.blue       = rgb[7:0];
        w.frame_done = 1'b0;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_word want;
        t_pixel_word ack;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                heat[i] = 8'd0;
            seed         = SEED_RESET;
            palette_mode = MODE_RED;
            expected_words.delete();
        end else begin
            // results first: nothing accepted at this edge can already be answered
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result with no request pending", 0, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_red !== want.red)
                        report_mismatch("red", i_red, want.red);
                    if (i_green !== want.green)
                        report_mismatch("green", i_green, want.green);
                    if (i_blue !== want.blue)
                        report_mismatch("blue", i_blue, want.blue);
                    if (i_frame_done !== want.frame_done)
                        report_mismatch("frame_done", i_frame_done, want.frame_done);
                    if (want.frame_done)
                        frames_seen++;
                    else
                        pixels_seen++;
                end
                words_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_ADVANCE) begin
                    advance_frame();
                    ack = '0;
                    ack.frame_done = 1'b1;
                    expected_words.push_back(ack);
                end else begin
                    expected_words.push_back(read_pixel(i_pixel_x, i_pixel_y));
                end
            end
            if (i_cfg_we)
                palette_mode = i_cfg_wdata;
        end
        o_outstanding <= expected_words.size();
    end

endmodule

[bench/tb_fire_effect_field_engine.sv]
`timescale 1ns / 1ps
// Testbench top for the fire effect field engine: stimulus, handshake pacing and verdict
module tb_fire_effect_field_engine;
    import ffe_pkg::*;

    localparam logic       CMD_PIXEL     = 1'b1;
    localparam logic [1:0] MODE_BLUE     = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT   = 2_000_000;
    localparam int         PHASE_WORDS   = 230;
    localparam int         LONG_HOLD     = 400;
    localparam int         HOLD_AT       = 120;
    localparam int         SETTLE_CYCLES = 16;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;

    int mismatches;
    int outstanding;
    int frames;
    int pixels;
    int frame_budget = 48;
    int tx_stretch_left = 0;
    bit tx_idle_on = 1'b0;
    bit quiet = 1'b0;
    int cycle_count = 0;

    logic [1:0] palette_plan [0:7] = '{MODE_GREEN, MODE_BLUE, MODE_SPARE, MODE_RED,
                                       MODE_SPARE, MODE_GREEN, MODE_BLUE, MODE_RED};

    fire_effect_field_engine u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_frame_done (frame_done)
    );

    fire_field_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_pixel_x     (pixel_x),
        .i_pixel_y     (pixel_y),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_frame_done  (frame_done),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_frames      (frames),
        .o_pixels      (pixels)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic offer_word(input logic c, input logic [8:0] x, input logic [7:0] y);
        in_valid <= 1'b1;
        cmd      <= c;
        pixel_x  <= x;
        pixel_y  <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tx_stretch_left == 0) begin
            tx_stretch_left = $urandom_range(20, 60);
            tx_idle_on      = ($urandom_range(0, 2) != 0);
        end
        tx_stretch_left--;
        if (!quiet && tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    task automatic random_word();
        logic [8:0] x;
        logic [7:0] y;
        int         pick;
        pick = $urandom_range(0, 99);
        if (frame_budget > 0 && pick < 3) begin
            frame_budget--;
            offer_word(CMD_ADVANCE, 9'($urandom), 8'($urandom));
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                x = 9'($urandom_range(0, 319));
                y = 8'($urandom_range(120, 199));
            end else if (pick < 8) begin
                x = 9'($urandom_range(0, 319));
                y = 8'($urandom_range(0, 199));
            end else if (pick == 8) begin
                x = 9'($urandom_range(0, 319));
                y = 8'($urandom_range(200, 239));
            end else begin
                x = 9'($urandom);
                y = 8'($urandom);
            end
            offer_word(CMD_PIXEL, x, y);
        end
    endtask

    task automatic set_palette(input logic [1:0] mode);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : receiver
        int stall_left;
        int stretch_left;
        int results_seen;
        bit stretch_idle;
        bit held;
        stall_left   = 0;
        stretch_left = 0;
        results_seen = 0;
        stretch_idle = 1'b0;
        held         = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                results_seen++;
            if (!held && results_seen == HOLD_AT) begin
                // hold off long enough for the engine to back up onto its input
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(50, 300);
                    stretch_idle = ($urandom_range(0, 2) != 0);
                end
                stretch_left--;
                if (stall_left == 0 && !quiet && stretch_idle && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 17);
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycle_count, outstanding);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= MODE_RED;
        in_valid  <= 1'b0;
        cmd       <= CMD_PIXEL;
        pixel_x   <= '0;
        pixel_y   <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        offer_word(CMD_PIXEL, 9'd0, 8'd0);
        offer_word(CMD_PIXEL, 9'd319, 8'd199);
        offer_word(CMD_PIXEL, 9'd320, 8'd0);
        offer_word(CMD_PIXEL, 9'd511, 8'd255);
        offer_word(CMD_PIXEL, 9'd0, 8'd240);
        offer_word(CMD_PIXEL, 9'd0, 8'd200);
        offer_word(CMD_PIXEL, 9'd319, 8'd239);
        offer_word(CMD_ADVANCE, 9'd511, 8'd255);
        offer_word(CMD_ADVANCE, 9'd0, 8'd0);
        offer_word(CMD_ADVANCE, 9'($urandom), 8'($urandom));
        offer_word(CMD_ADVANCE, 9'($urandom), 8'($urandom));
        offer_word(CMD_PIXEL, 9'd0, 8'd199);
        offer_word(CMD_PIXEL, 9'd3, 8'd198);
        offer_word(CMD_PIXEL, 9'd319, 8'd198);
        offer_word(CMD_PIXEL, 9'd316, 8'd197);
        offer_word(CMD_PIXEL, 9'd160, 8'd196);
        offer_word(CMD_PIXEL, 9'd4, 8'd194);
        offer_word(CMD_PIXEL, 9'd255, 8'd193);
        offer_word(CMD_PIXEL, 9'd256, 8'd192);
        offer_word(CMD_PIXEL, 9'd100, 8'd127);
        offer_word(CMD_PIXEL, 9'd200, 8'd128);

        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                quiet = 1'b1;
            set_palette(palette_plan[p]);
            repeat (PHASE_WORDS)
                random_word();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("checked %0d frame advances and %0d pixel reads across all four palette codes,",
                 frames, pixels);
        $display("with off-screen, strip and field pixels, idle bursts and a %0d-cycle back-up",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/ffe_pkg.sv
sv/ffe_ram.sv
sv/fire_effect_field_engine.sv
sv/ffe_checker.sv
bench/fire_field_checker.sv
bench/tb_fire_effect_field_engine.sv
